/* src/iwlf_pkg.sv */
`default_nettype none
package iwlf_pkg;

    localparam int COORD_FRAC_BITS = 20;
    localparam int OUT_FRAC_BITS = 16;
    localparam int MAX_HITS = 255;

    localparam int W_W = 16;
    localparam int C_W = 24;
    localparam int CNT_W = 8;
    localparam int WA_W = W_W + 1 + C_W;
    localparam int PP_W = 2 * C_W;
    localparam int SW_W = 24;
    localparam int S1_W = 48;
    localparam int S2_W = 72;
    localparam int WAA_W = W_W + PP_W;
    localparam int WAB_W = W_W + 1 + PP_W;

    localparam int OP_W = S2_W;
    localparam int WIDE_W = 128;
    localparam int DIG_W = 16;
    localparam int NDIG = (OP_W + DIG_W - 1) / DIG_W;
    localparam int MB_W = NDIG * DIG_W;
    localparam int MACC_W = OP_W + MB_W;
    localparam int MCNT_W = $clog2(NDIG + 1);

    localparam int Q_W = 32;
    localparam int ICPT_NSH = (OUT_FRAC_BITS > COORD_FRAC_BITS) ?
                              (OUT_FRAC_BITS - COORD_FRAC_BITS) : 0;
    localparam int ICPT_DSH = (COORD_FRAC_BITS > OUT_FRAC_BITS) ?
                              (COORD_FRAC_BITS - OUT_FRAC_BITS) : 0;
    localparam int SLOPE_NSH = OUT_FRAC_BITS;
    localparam int DIV_W = 176;
    localparam int DSTEPS = Q_W + 1;
    localparam int DCNT_W = $clog2(DSTEPS + 1);

    typedef struct packed {
        logic [W_W-1:0]         w;
        logic signed [WA_W-1:0] wa;
        logic [PP_W-1:0]        aa;
        logic signed [WA_W-1:0] wb;
        logic signed [PP_W-1:0] ab;
    } plane_terms_t;

    typedef struct packed {
        logic         start;
        plane_terms_t xy;
        plane_terms_t sz;
    } hit_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_ACC,
        B_SUM,
        B_MUL_GO,
        B_MUL_WAIT,
        B_CHECK,
        B_DIV_GO,
        B_DIV_WAIT,
        B_DONE
    } back_state_t;

    typedef enum logic [2:0] {
        M_DET_A,
        M_DET_B,
        M_ICPT_A,
        M_ICPT_B,
        M_SLOPE_A,
        M_SLOPE_B
    } mul_step_t;

endpackage
`default_nettype wire

/* src/iwlf_front.sv */
`default_nettype none
module iwlf_front (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  push,
    output logic                                       full,
    input  wire logic                                  start_track,
    input  wire logic [iwlf_pkg::W_W-1:0]              xy_weight,
    input  wire logic signed [iwlf_pkg::C_W-1:0]       x_conformal,
    input  wire logic signed [iwlf_pkg::C_W-1:0]       y_conformal,
    input  wire logic [iwlf_pkg::W_W-1:0]              z_weight,
    input  wire logic signed [iwlf_pkg::C_W-1:0]       path_length,
    input  wire logic signed [iwlf_pkg::C_W-1:0]       z_position,
    output iwlf_pkg::hit_t                             head,
    output logic                                       head_valid,
    input  wire logic                                  take
);

    iwlf_pkg::hit_t entry_reg [2];
    iwlf_pkg::hit_t item;
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     cnt_reg;
    logic           accept;

    assign full = (cnt_reg == 2'd2);
    assign accept = push && !full;
    assign head = entry_reg[rd_ptr_reg];
    assign head_valid = (cnt_reg != 2'd0);

    // first-level products of each hit
    always_comb
    begin
        item.start = start_track;
        item.xy.w = xy_weight;
        item.xy.wa = $signed({1'b0, xy_weight}) * x_conformal;
        item.xy.aa = x_conformal * x_conformal;
        item.xy.wb = $signed({1'b0, xy_weight}) * y_conformal;
        item.xy.ab = x_conformal * y_conformal;
        item.sz.w = z_weight;
        item.sz.wa = $signed({1'b0, z_weight}) * path_length;
        item.sz.aa = path_length * path_length;
        item.sz.wb = $signed({1'b0, z_weight}) * z_position;
        item.sz.ab = path_length * z_position;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            entry_reg[wr_ptr_reg] <= item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (accept)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (take)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            unique case ({accept, take})
                2'b10:   cnt_reg <= cnt_reg + 2'd1;
                2'b01:   cnt_reg <= cnt_reg - 2'd1;
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

endmodule
`default_nettype wire

/* src/iwlf_mul.sv */
`default_nettype none
module iwlf_mul (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  start,
    input  wire logic signed [iwlf_pkg::OP_W-1:0]      a,
    input  wire logic signed [iwlf_pkg::OP_W-1:0]      b,
    output logic                                       done,
    output logic signed [iwlf_pkg::WIDE_W-1:0]         p
);

    logic [iwlf_pkg::OP_W-1:0]               ma_reg;
    logic [iwlf_pkg::MB_W-1:0]               mb_reg;
    logic [iwlf_pkg::MACC_W-1:0]             acc_reg;
    logic                                    neg_reg;
    logic [iwlf_pkg::MCNT_W-1:0]             cnt_reg;
    logic                                    run_reg;
    logic                                    done_reg;
    logic [iwlf_pkg::OP_W-1:0]               abs_a;
    logic [iwlf_pkg::OP_W-1:0]               abs_b;
    logic [iwlf_pkg::OP_W+iwlf_pkg::DIG_W-1:0] partial;

    assign abs_a = a[iwlf_pkg::OP_W-1] ? iwlf_pkg::OP_W'(-a) : iwlf_pkg::OP_W'(a);
    assign abs_b = b[iwlf_pkg::OP_W-1] ? iwlf_pkg::OP_W'(-b) : iwlf_pkg::OP_W'(b);
    // one 16-bit digit of b per cycle, msb first
    assign partial = ma_reg * mb_reg[iwlf_pkg::MB_W-1 -: iwlf_pkg::DIG_W];
    assign done = done_reg;
    assign p = neg_reg ? -$signed(acc_reg[iwlf_pkg::WIDE_W-1:0])
                       : $signed(acc_reg[iwlf_pkg::WIDE_W-1:0]);

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            ma_reg <= abs_a;
            mb_reg <= iwlf_pkg::MB_W'(abs_b);
            acc_reg <= '0;
            neg_reg <= a[iwlf_pkg::OP_W-1] ^ b[iwlf_pkg::OP_W-1];
        end
        else if (run_reg)
        begin
            acc_reg <= {acc_reg[iwlf_pkg::MACC_W-iwlf_pkg::DIG_W-1:0],
                        {iwlf_pkg::DIG_W{1'b0}}} + iwlf_pkg::MACC_W'(partial);
            mb_reg <= mb_reg << iwlf_pkg::DIG_W;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            done_reg <= run_reg && !start && (cnt_reg == iwlf_pkg::MCNT_W'(1));
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= iwlf_pkg::MCNT_W'(iwlf_pkg::NDIG);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - iwlf_pkg::MCNT_W'(1);
                if (cnt_reg == iwlf_pkg::MCNT_W'(1))
                begin
                    run_reg <= 1'b0;
                end
            end
        end
    end

endmodule
`default_nettype wire

/* src/iwlf_div.sv */
`default_nettype none
module iwlf_div (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  start,
    input  wire logic                                  slope,
    input  wire logic signed [iwlf_pkg::WIDE_W-1:0]    num,
    input  wire logic signed [iwlf_pkg::WIDE_W-1:0]    den,
    output logic                                       done,
    output logic [iwlf_pkg::Q_W-1:0]                   q
);

    logic [iwlf_pkg::DIV_W-1:0]   r_reg;
    logic [iwlf_pkg::DIV_W-1:0]   dsh_reg;
    logic [iwlf_pkg::Q_W:0]       q_reg;
    logic                         neg_reg;
    logic [iwlf_pkg::DCNT_W-1:0]  cnt_reg;
    logic                         run_reg;
    logic                         done_reg;
    logic [iwlf_pkg::WIDE_W-1:0]  abs_n;
    logic [iwlf_pkg::WIDE_W-1:0]  abs_d;
    logic [iwlf_pkg::DIV_W-1:0]   n_ext;
    logic [iwlf_pkg::DIV_W-1:0]   d_ext;
    logic                         ge;
    logic                         over_pos;
    logic                         over_neg;

    assign abs_n = num[iwlf_pkg::WIDE_W-1] ? iwlf_pkg::WIDE_W'(-num)
                                           : iwlf_pkg::WIDE_W'(num);
    assign abs_d = den[iwlf_pkg::WIDE_W-1] ? iwlf_pkg::WIDE_W'(-den)
                                           : iwlf_pkg::WIDE_W'(den);
    assign n_ext = slope ? (iwlf_pkg::DIV_W'(abs_n) << iwlf_pkg::SLOPE_NSH)
                         : (iwlf_pkg::DIV_W'(abs_n) << iwlf_pkg::ICPT_NSH);
    assign d_ext = slope ? iwlf_pkg::DIV_W'(abs_d)
                         : (iwlf_pkg::DIV_W'(abs_d) << iwlf_pkg::ICPT_DSH);
    assign ge = (r_reg >= dsh_reg);

    // quotient does not fit in Q_W signed bits: bit Q_W set, or bit Q_W-1 set (alone allowed if negative)
    assign over_pos = q_reg[iwlf_pkg::Q_W] | q_reg[iwlf_pkg::Q_W-1];
    assign over_neg = q_reg[iwlf_pkg::Q_W] |
                      (q_reg[iwlf_pkg::Q_W-1] & (|q_reg[iwlf_pkg::Q_W-2:0]));
    assign done = done_reg;

    always_comb
    begin
        if (neg_reg)
        begin
            q = over_neg ? {1'b1, {(iwlf_pkg::Q_W-1){1'b0}}}
                         : iwlf_pkg::Q_W'(-q_reg[iwlf_pkg::Q_W-1:0]);
        end
        else
        begin
            q = over_pos ? {1'b0, {(iwlf_pkg::Q_W-1){1'b1}}}
                         : q_reg[iwlf_pkg::Q_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            r_reg <= n_ext;
            dsh_reg <= d_ext << iwlf_pkg::Q_W;
            q_reg <= '0;
            neg_reg <= num[iwlf_pkg::WIDE_W-1] ^ den[iwlf_pkg::WIDE_W-1];
        end
        else if (run_reg)
        begin
            if (ge)
            begin
                r_reg <= r_reg - dsh_reg;
            end
            q_reg <= {q_reg[iwlf_pkg::Q_W-1:0], ge};
            dsh_reg <= dsh_reg >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            done_reg <= run_reg && !start && (cnt_reg == iwlf_pkg::DCNT_W'(1));
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= iwlf_pkg::DCNT_W'(iwlf_pkg::DSTEPS);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - iwlf_pkg::DCNT_W'(1);
                if (cnt_reg == iwlf_pkg::DCNT_W'(1))
                begin
                    run_reg <= 1'b0;
                end
            end
        end
    end

endmodule
`default_nettype wire

/* src/iwlf_back.sv */
`default_nettype none
module iwlf_back (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire iwlf_pkg::hit_t                        head,
    input  wire logic                                  head_valid,
    output logic                                       take,
    input  wire logic                                  pop,
    output logic                                       empty,
    output logic [iwlf_pkg::CNT_W-1:0]                 hit_count,
    output logic signed [iwlf_pkg::Q_W-1:0]            xy_intercept,
    output logic signed [iwlf_pkg::Q_W-1:0]            xy_slope,
    output logic                                       xy_valid,
    output logic signed [iwlf_pkg::Q_W-1:0]            sz_intercept,
    output logic signed [iwlf_pkg::Q_W-1:0]            sz_slope,
    output logic                                       sz_valid
);

    iwlf_pkg::back_state_t state_reg;
    iwlf_pkg::back_state_t state_next;
    iwlf_pkg::mul_step_t   mstep_reg;
    iwlf_pkg::mul_step_t   mstep_next;
    iwlf_pkg::hit_t        ent_reg;
    iwlf_pkg::plane_terms_t tm [2];

    logic [iwlf_pkg::CNT_W-1:0]          cnt_reg;
    logic [iwlf_pkg::SW_W-1:0]           sw_reg [2];
    logic signed [iwlf_pkg::S1_W-1:0]    sa_reg [2];
    logic signed [iwlf_pkg::S2_W-1:0]    saa_reg [2];
    logic signed [iwlf_pkg::S1_W-1:0]    sb_reg [2];
    logic signed [iwlf_pkg::S2_W-1:0]    sab_reg [2];
    logic [iwlf_pkg::SW_W-1:0]           sw_next [2];
    logic signed [iwlf_pkg::S1_W-1:0]    sa_next [2];
    logic signed [iwlf_pkg::S2_W-1:0]    saa_next [2];
    logic signed [iwlf_pkg::S1_W-1:0]    sb_next [2];
    logic signed [iwlf_pkg::S2_W-1:0]    sab_next [2];
    logic [iwlf_pkg::CNT_W-1:0]          cnt_next;
    logic [iwlf_pkg::WAA_W-1:0]          waa_reg [2];
    logic signed [iwlf_pkg::WAB_W-1:0]   wab_reg [2];

    logic                                plane_reg;
    logic                                dstep_reg;
    logic signed [iwlf_pkg::WIDE_W-1:0]  det_reg;
    logic signed [iwlf_pkg::WIDE_W-1:0]  num1_reg;
    logic signed [iwlf_pkg::WIDE_W-1:0]  num2_reg;
    logic [iwlf_pkg::Q_W-1:0]            fit_reg [4];
    logic [1:0]                          valid_reg;
    logic                                out_full_reg;
    logic [iwlf_pkg::CNT_W-1:0]          out_cnt_reg;
    logic [iwlf_pkg::Q_W-1:0]            out_fit_reg [4];
    logic [1:0]                          out_valid_reg;

    logic [iwlf_pkg::CNT_W-1:0]          base_cnt;
    logic                                add_en;
    logic signed [iwlf_pkg::OP_W-1:0]    op_a;
    logic signed [iwlf_pkg::OP_W-1:0]    op_b;
    logic signed [iwlf_pkg::OP_W-1:0]    op_s;
    logic signed [iwlf_pkg::OP_W-1:0]    op_sa;
    logic signed [iwlf_pkg::OP_W-1:0]    op_saa;
    logic signed [iwlf_pkg::OP_W-1:0]    op_sb;
    logic signed [iwlf_pkg::OP_W-1:0]    op_sab;
    logic                                mul_start;
    logic                                mul_done;
    logic signed [iwlf_pkg::WIDE_W-1:0]  mul_p;
    logic                                div_start;
    logic                                div_done;
    logic [iwlf_pkg::Q_W-1:0]            div_q;
    logic                                det_zero;

    assign tm[0] = ent_reg.xy;
    assign tm[1] = ent_reg.sz;
    assign det_zero = (det_reg == '0);

    // accumulate, start flag clears first, full track is left unchanged
    always_comb
    begin
        base_cnt = ent_reg.start ? '0 : cnt_reg;
        add_en = (base_cnt < iwlf_pkg::CNT_W'(iwlf_pkg::MAX_HITS));
        cnt_next = add_en ? (base_cnt + iwlf_pkg::CNT_W'(1)) : base_cnt;
        for (int p = 0; p < 2; p++)
        begin
            sw_next[p] = ent_reg.start ? '0 : sw_reg[p];
            sa_next[p] = ent_reg.start ? '0 : sa_reg[p];
            saa_next[p] = ent_reg.start ? '0 : saa_reg[p];
            sb_next[p] = ent_reg.start ? '0 : sb_reg[p];
            sab_next[p] = ent_reg.start ? '0 : sab_reg[p];
            if (add_en)
            begin
                sw_next[p] = sw_next[p] + iwlf_pkg::SW_W'(tm[p].w);
                sa_next[p] = sa_next[p] + iwlf_pkg::S1_W'($signed(tm[p].wa));
                saa_next[p] = saa_next[p] +
                              iwlf_pkg::S2_W'($signed({1'b0, waa_reg[p]}));
                sb_next[p] = sb_next[p] + iwlf_pkg::S1_W'($signed(tm[p].wb));
                sab_next[p] = sab_next[p] + iwlf_pkg::S2_W'(wab_reg[p]);
            end
        end
    end

    always_comb
    begin
        op_s = $signed({{(iwlf_pkg::OP_W-iwlf_pkg::SW_W){1'b0}}, sw_reg[plane_reg]});
        op_sa = iwlf_pkg::OP_W'(sa_reg[plane_reg]);
        op_saa = iwlf_pkg::OP_W'(saa_reg[plane_reg]);
        op_sb = iwlf_pkg::OP_W'(sb_reg[plane_reg]);
        op_sab = iwlf_pkg::OP_W'(sab_reg[plane_reg]);
        unique case (mstep_reg)
            iwlf_pkg::M_DET_A:
            begin
                op_a = op_s;
                op_b = op_saa;
                mstep_next = iwlf_pkg::M_DET_B;
            end
            iwlf_pkg::M_DET_B:
            begin
                op_a = op_sa;
                op_b = op_sa;
                mstep_next = iwlf_pkg::M_ICPT_A;
            end
            iwlf_pkg::M_ICPT_A:
            begin
                op_a = op_sb;
                op_b = op_saa;
                mstep_next = iwlf_pkg::M_ICPT_B;
            end
            iwlf_pkg::M_ICPT_B:
            begin
                op_a = op_sab;
                op_b = op_sa;
                mstep_next = iwlf_pkg::M_SLOPE_A;
            end
            iwlf_pkg::M_SLOPE_A:
            begin
                op_a = op_sab;
                op_b = op_s;
                mstep_next = iwlf_pkg::M_SLOPE_B;
            end
            iwlf_pkg::M_SLOPE_B:
            begin
                op_a = op_sb;
                op_b = op_sa;
                mstep_next = iwlf_pkg::M_DET_A;
            end
            default:
            begin
                op_a = op_s;
                op_b = op_saa;
                mstep_next = iwlf_pkg::M_DET_A;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            iwlf_pkg::B_IDLE:
            begin
                if (head_valid && !out_full_reg)
                begin
                    state_next = iwlf_pkg::B_ACC;
                end
            end
            iwlf_pkg::B_ACC:      state_next = iwlf_pkg::B_SUM;
            iwlf_pkg::B_SUM:      state_next = iwlf_pkg::B_MUL_GO;
            iwlf_pkg::B_MUL_GO:   state_next = iwlf_pkg::B_MUL_WAIT;
            iwlf_pkg::B_MUL_WAIT:
            begin
                if (mul_done)
                begin
                    state_next = (mstep_reg == iwlf_pkg::M_SLOPE_B) ?
                                 iwlf_pkg::B_CHECK : iwlf_pkg::B_MUL_GO;
                end
            end
            iwlf_pkg::B_CHECK:
            begin
                if (!det_zero)
                begin
                    state_next = iwlf_pkg::B_DIV_GO;
                end
                else
                begin
                    state_next = plane_reg ? iwlf_pkg::B_DONE : iwlf_pkg::B_MUL_GO;
                end
            end
            iwlf_pkg::B_DIV_GO:   state_next = iwlf_pkg::B_DIV_WAIT;
            iwlf_pkg::B_DIV_WAIT:
            begin
                if (div_done)
                begin
                    if (!dstep_reg)
                    begin
                        state_next = iwlf_pkg::B_DIV_GO;
                    end
                    else
                    begin
                        state_next = plane_reg ? iwlf_pkg::B_DONE
                                               : iwlf_pkg::B_MUL_GO;
                    end
                end
            end
            iwlf_pkg::B_DONE:     state_next = iwlf_pkg::B_IDLE;
            default:              state_next = iwlf_pkg::B_IDLE;
        endcase
    end

    always_comb
    begin
        take = (state_reg == iwlf_pkg::B_IDLE) && head_valid && !out_full_reg;
        mul_start = (state_reg == iwlf_pkg::B_MUL_GO);
        div_start = (state_reg == iwlf_pkg::B_DIV_GO);
    end

    iwlf_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (op_a),
        .b     (op_b),
        .done  (mul_done),
        .p     (mul_p)
    );

    iwlf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .slope (dstep_reg),
        .num   (dstep_reg ? num2_reg : num1_reg),
        .den   (det_reg),
        .done  (div_done),
        .q     (div_q)
    );

    // payload without reset
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            ent_reg <= head;
        end
        if (state_reg == iwlf_pkg::B_ACC)
        begin
            for (int p = 0; p < 2; p++)
            begin
                waa_reg[p] <= tm[p].w * tm[p].aa;
                wab_reg[p] <= $signed({1'b0, tm[p].w}) * tm[p].ab;
            end
        end
        if (state_reg == iwlf_pkg::B_MUL_WAIT && mul_done)
        begin
            unique case (mstep_reg)
                iwlf_pkg::M_DET_A:   det_reg <= mul_p;
                iwlf_pkg::M_DET_B:   det_reg <= det_reg - mul_p;
                iwlf_pkg::M_ICPT_A:  num1_reg <= mul_p;
                iwlf_pkg::M_ICPT_B:  num1_reg <= num1_reg - mul_p;
                iwlf_pkg::M_SLOPE_A: num2_reg <= mul_p;
                iwlf_pkg::M_SLOPE_B: num2_reg <= num2_reg - mul_p;
                default:             det_reg <= det_reg;
            endcase
        end
        if (state_reg == iwlf_pkg::B_DONE)
        begin
            out_cnt_reg <= cnt_reg;
            out_fit_reg <= fit_reg;
            out_valid_reg <= valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= iwlf_pkg::B_IDLE;
            mstep_reg <= iwlf_pkg::M_DET_A;
            plane_reg <= 1'b0;
            dstep_reg <= 1'b0;
            cnt_reg <= '0;
            valid_reg <= '0;
            out_full_reg <= 1'b0;
            for (int p = 0; p < 2; p++)
            begin
                sw_reg[p] <= '0;
                sa_reg[p] <= '0;
                saa_reg[p] <= '0;
                sb_reg[p] <= '0;
                sab_reg[p] <= '0;
            end
            for (int i = 0; i < 4; i++)
            begin
                fit_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                iwlf_pkg::B_SUM:
                begin
                    cnt_reg <= cnt_next;
                    sw_reg <= sw_next;
                    sa_reg <= sa_next;
                    saa_reg <= saa_next;
                    sb_reg <= sb_next;
                    sab_reg <= sab_next;
                    plane_reg <= 1'b0;
                    mstep_reg <= iwlf_pkg::M_DET_A;
                end
                iwlf_pkg::B_MUL_WAIT:
                begin
                    if (mul_done)
                    begin
                        mstep_reg <= mstep_next;
                    end
                end
                iwlf_pkg::B_CHECK:
                begin
                    dstep_reg <= 1'b0;
                    if (det_zero)
                    begin
                        valid_reg[plane_reg] <= 1'b0;
                        plane_reg <= 1'b1;
                    end
                end
                iwlf_pkg::B_DIV_WAIT:
                begin
                    if (div_done)
                    begin
                        fit_reg[{plane_reg, dstep_reg}] <= div_q;
                        dstep_reg <= 1'b1;
                        if (dstep_reg)
                        begin
                            valid_reg[plane_reg] <= 1'b1;
                            plane_reg <= 1'b1;
                        end
                    end
                end
                default:
                begin
                end
            endcase
            if (state_reg == iwlf_pkg::B_DONE)
            begin
                out_full_reg <= 1'b1;
            end
            else if (pop && out_full_reg)
            begin
                out_full_reg <= 1'b0;
            end
        end
    end

    assign empty = !out_full_reg;
    assign hit_count = out_cnt_reg;
    assign xy_intercept = out_fit_reg[0];
    assign xy_slope = out_fit_reg[1];
    assign xy_valid = out_valid_reg[0];
    assign sz_intercept = out_fit_reg[2];
    assign sz_slope = out_fit_reg[3];
    assign sz_valid = out_valid_reg[1];

endmodule
`default_nettype wire

/* src/incremental_weighted_line_fit.sv */
// channel   handshake            payload
// hits      push / full          start_track, xy_weight, x_conformal, y_conformal,
//                                z_weight, path_length, z_position
// results   empty / pop          hit_count, xy_intercept, xy_slope, xy_valid,
//                                sz_intercept, sz_slope, sz_valid
//
// per hit: accumulate states B_ACC and B_SUM, then per plane six 72x72 products
// on one digit-serial multiplier (16 bits a cycle) and two 33-step
// quotients on one restoring divider; a plane with zero determinant skips its divides
// a two-entry input queue takes hits while the back end works; one result register
// holds a finished transaction, and the back end waits while it is still full
// asynchronous active-low reset clears sums, count, fits and both queues
`default_nettype none
module incremental_weighted_line_fit (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  push,
    output logic                                       full,
    input  wire logic                                  start_track,
    input  wire logic [iwlf_pkg::W_W-1:0]              xy_weight,
    input  wire logic signed [iwlf_pkg::C_W-1:0]       x_conformal,
    input  wire logic signed [iwlf_pkg::C_W-1:0]       y_conformal,
    input  wire logic [iwlf_pkg::W_W-1:0]              z_weight,
    input  wire logic signed [iwlf_pkg::C_W-1:0]       path_length,
    input  wire logic signed [iwlf_pkg::C_W-1:0]       z_position,
    output logic                                       empty,
    input  wire logic                                  pop,
    output logic [iwlf_pkg::CNT_W-1:0]                 hit_count,
    output logic signed [iwlf_pkg::Q_W-1:0]            xy_intercept,
    output logic signed [iwlf_pkg::Q_W-1:0]            xy_slope,
    output logic                                       xy_valid,
    output logic signed [iwlf_pkg::Q_W-1:0]            sz_intercept,
    output logic signed [iwlf_pkg::Q_W-1:0]            sz_slope,
    output logic                                       sz_valid
);

    iwlf_pkg::hit_t head;
    logic           head_valid;
    logic           take;

    iwlf_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .start_track (start_track),
        .xy_weight   (xy_weight),
        .x_conformal (x_conformal),
        .y_conformal (y_conformal),
        .z_weight    (z_weight),
        .path_length (path_length),
        .z_position  (z_position),
        .head        (head),
        .head_valid  (head_valid),
        .take        (take)
    );

    iwlf_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .head_valid   (head_valid),
        .take         (take),
        .pop          (pop),
        .empty        (empty),
        .hit_count    (hit_count),
        .xy_intercept (xy_intercept),
        .xy_slope     (xy_slope),
        .xy_valid     (xy_valid),
        .sz_intercept (sz_intercept),
        .sz_slope     (sz_slope),
        .sz_valid     (sz_valid)
    );

endmodule
`default_nettype wire

/* tb/sv/incremental_weighted_line_fit_tb.sv */
`default_nettype none
module incremental_weighted_line_fit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic                             start;
        logic [iwlf_pkg::W_W-1:0]         xw;
        logic signed [iwlf_pkg::C_W-1:0]  x;
        logic signed [iwlf_pkg::C_W-1:0]  y;
        logic [iwlf_pkg::W_W-1:0]         zw;
        logic signed [iwlf_pkg::C_W-1:0]  s;
        logic signed [iwlf_pkg::C_W-1:0]  z;
    } hit_item_t;

    typedef struct {
        logic [iwlf_pkg::CNT_W-1:0]       cnt;
        logic signed [iwlf_pkg::Q_W-1:0]  xy_icpt;
        logic signed [iwlf_pkg::Q_W-1:0]  xy_slope;
        logic                             xy_ok;
        logic signed [iwlf_pkg::Q_W-1:0]  sz_icpt;
        logic signed [iwlf_pkg::Q_W-1:0]  sz_slope;
        logic                             sz_ok;
    } fit_result_t;

    typedef logic signed [255:0] big_t;

    class fit_scoreboard;
        int                         errors;
        fit_result_t                pending_fits[$];
        int                         n_hits;
        big_t                       sums[2][5];
        logic [iwlf_pkg::Q_W-1:0]   fits[4];

        function new();
            errors = 0;
            n_hits = 0;
            foreach (sums[p, i]) sums[p][i] = '0;
            foreach (fits[i]) fits[i] = '0;
        endfunction

        function logic [iwlf_pkg::Q_W-1:0] div_sat(big_t num, big_t den);
            logic        neg;
            logic [255:0] nm;
            logic [255:0] dm;
            logic [255:0] q;
            neg = (num < 0) ^ (den < 0);
            nm = (num < 0) ? -num : num;
            dm = (den < 0) ? -den : den;
            q = nm / dm;
            if (neg)
                return (q > 256'h8000_0000) ? 32'h8000_0000 : -q[31:0];
            return (q > 256'h7fff_ffff) ? 32'h7fff_ffff : q[31:0];
        endfunction

        function void add_plane(int p, logic [iwlf_pkg::W_W-1:0] w,
                                logic signed [iwlf_pkg::C_W-1:0] a,
                                logic signed [iwlf_pkg::C_W-1:0] b);
            big_t wv;
            big_t av;
            big_t bv;
            wv = $signed({240'b0, w});
            av = a;
            bv = b;
            sums[p][0] += wv;
            sums[p][1] += wv * av;
            sums[p][2] += wv * av * av;
            sums[p][3] += wv * bv;
            sums[p][4] += wv * av * bv;
        endfunction

        function logic solve_plane(int p);
            big_t det;
            det = sums[p][0] * sums[p][2] - sums[p][1] * sums[p][1];
            if (det == 0)
                return 1'b0;
            fits[2*p] = div_sat(sums[p][3] * sums[p][2] - sums[p][4] * sums[p][1],
                                det <<< (iwlf_pkg::COORD_FRAC_BITS -
                                         iwlf_pkg::OUT_FRAC_BITS));
            fits[2*p+1] = div_sat((sums[p][4] * sums[p][0] - sums[p][3] * sums[p][1])
                                  <<< iwlf_pkg::OUT_FRAC_BITS, det);
            return 1'b1;
        endfunction

        function void note_hit(hit_item_t h);
            fit_result_t r;
            if (h.start)
            begin
                n_hits = 0;
                foreach (sums[p, i]) sums[p][i] = '0;
            end
            if (n_hits < iwlf_pkg::MAX_HITS)
            begin
                n_hits++;
                add_plane(0, h.xw, h.x, h.y);
                add_plane(1, h.zw, h.s, h.z);
            end
            r.xy_ok = solve_plane(0);
            r.sz_ok = solve_plane(1);
            r.cnt = n_hits[iwlf_pkg::CNT_W-1:0];
            r.xy_icpt = fits[0];
            r.xy_slope = fits[1];
            r.sz_icpt = fits[2];
            r.sz_slope = fits[3];
            pending_fits.push_back(r);
        endfunction

        function void check_fit(fit_result_t a);
            fit_result_t e;
            if (pending_fits.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result transaction, count %0d", $time, a.cnt);
                return;
            end
            e = pending_fits.pop_front();
            if (a.cnt !== e.cnt)
            begin
                errors++;
                $display("%0t: hit_count exp %0d got %0d", $time, e.cnt, a.cnt);
            end
            if (a.xy_icpt !== e.xy_icpt)
            begin
                errors++;
                $display("%0t: xy_intercept exp %h got %h", $time, e.xy_icpt, a.xy_icpt);
            end
            if (a.xy_slope !== e.xy_slope)
            begin
                errors++;
                $display("%0t: xy_slope exp %h got %h", $time, e.xy_slope, a.xy_slope);
            end
            if (a.xy_ok !== e.xy_ok)
            begin
                errors++;
                $display("%0t: xy_valid exp %b got %b", $time, e.xy_ok, a.xy_ok);
            end
            if (a.sz_icpt !== e.sz_icpt)
            begin
                errors++;
                $display("%0t: sz_intercept exp %h got %h", $time, e.sz_icpt, a.sz_icpt);
            end
            if (a.sz_slope !== e.sz_slope)
            begin
                errors++;
                $display("%0t: sz_slope exp %h got %h", $time, e.sz_slope, a.sz_slope);
            end
            if (a.sz_ok !== e.sz_ok)
            begin
                errors++;
                $display("%0t: sz_valid exp %b got %b", $time, e.sz_ok, a.sz_ok);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic push;
    logic full;
    logic start_track;
    logic [iwlf_pkg::W_W-1:0] xy_weight;
    logic signed [iwlf_pkg::C_W-1:0] x_conformal;
    logic signed [iwlf_pkg::C_W-1:0] y_conformal;
    logic [iwlf_pkg::W_W-1:0] z_weight;
    logic signed [iwlf_pkg::C_W-1:0] path_length;
    logic signed [iwlf_pkg::C_W-1:0] z_position;
    logic empty;
    logic pop;
    logic [iwlf_pkg::CNT_W-1:0] hit_count;
    logic signed [iwlf_pkg::Q_W-1:0] xy_intercept;
    logic signed [iwlf_pkg::Q_W-1:0] xy_slope;
    logic xy_valid;
    logic signed [iwlf_pkg::Q_W-1:0] sz_intercept;
    logic signed [iwlf_pkg::Q_W-1:0] sz_slope;
    logic sz_valid;

    fit_scoreboard sb;
    int tx_idle_pct;
    int rx_stall_pct;
    longint cycles;

    incremental_weighted_line_fit dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > 3000000)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    always @(posedge clk)
    begin
        fit_result_t a;
        if (rst_n && push && !full)
            sb.note_hit('{start_track, xy_weight, x_conformal, y_conformal,
                          z_weight, path_length, z_position});
        if (rst_n && pop && !empty)
        begin
            a = '{hit_count, xy_intercept, xy_slope, xy_valid,
                  sz_intercept, sz_slope, sz_valid};
            sb.check_fit(a);
        end
    end

    // long hold-off first so the input side backs up
    initial
    begin
        pop = 1'b0;
        @(posedge rst_n);
        repeat (3000) @(negedge clk) pop = 1'b0;
        forever @(negedge clk) pop = ($urandom_range(99) >= rx_stall_pct);
    end

    function logic signed [iwlf_pkg::C_W-1:0] rand_coord();
        case ($urandom_range(3))
            0: return $signed(24'($urandom_range(255))) - 24'sd128;
            1: return $urandom_range(1) ? 24'sh7fffff : 24'sh800000;
            default: return 24'($urandom);
        endcase
    endfunction

    function logic [iwlf_pkg::W_W-1:0] rand_weight();
        case ($urandom_range(5))
            0: return '0;
            1: return 16'hffff;
            2: return 16'($urandom_range(512));
            default: return 16'($urandom);
        endcase
    endfunction

    function hit_item_t rand_hit(logic st);
        hit_item_t h;
        h.start = st;
        h.xw = rand_weight();
        h.x = rand_coord();
        h.y = rand_coord();
        h.zw = rand_weight();
        h.s = rand_coord();
        h.z = rand_coord();
        return h;
    endfunction

    // called at a falling edge, returns at a falling edge
    task send_hit(hit_item_t h);
        push = 1'b1;
        start_track = h.start;
        xy_weight = h.xw;
        x_conformal = h.x;
        y_conformal = h.y;
        z_weight = h.zw;
        path_length = h.s;
        z_position = h.z;
        @(posedge clk);
        while (full) @(posedge clk);
        @(negedge clk);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            push = 1'b0;
            @(negedge clk);
        end
    endtask

    task send_track(int len);
        for (int i = 0; i < len; i++)
            send_hit(rand_hit(i == 0 || $urandom_range(49) == 0));
    endtask

    initial
    begin
        sb = new();
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        rst_n = 1'b0;
        push = 1'b0;
        start_track = 1'b0;
        xy_weight = '0;
        x_conformal = '0;
        y_conformal = '0;
        z_weight = '0;
        path_length = '0;
        z_position = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // single hit leaves both determinants zero
        send_hit('{1'b1, 16'h0100, 24'sh100000, 24'sh200000, 16'h0100,
                   24'sh100000, -24'sh080000});
        send_hit('{1'b0, 16'h0100, 24'sh200000, 24'sh300000, 16'h0100,
                   24'sh300000, 24'sh080000});
        send_hit('{1'b0, 16'hffff, 24'sh7fffff, 24'sh800000, 16'hffff,
                   24'sh800000, 24'sh7fffff});
        send_hit('{1'b0, 16'hffff, 24'sh800000, 24'sh7fffff, 16'hffff,
                   24'sh7fffff, 24'sh800000});
        // zero weights keep previous fits
        send_hit('{1'b1, 16'h0000, 24'sh7fffff, 24'sh7fffff, 16'h0000,
                   24'sh800000, 24'sh800000});
        send_hit('{1'b0, 16'h0000, 24'sh123456, -24'sh123456, 16'h0000,
                   24'sh001000, 24'sh002000});
        // same abscissa twice
        send_hit('{1'b1, 16'h0200, 24'sh050000, 24'sh010000, 16'h0001,
                   24'sh000000, 24'sh7fffff});
        send_hit('{1'b0, 16'h0300, 24'sh050000, 24'sh7fffff, 16'h0001,
                   24'sh000000, 24'sh800000});
        // near-vertical slopes push saturation
        send_hit('{1'b1, 16'hffff, 24'sh000000, 24'sh800000, 16'hffff,
                   24'sh000000, 24'sh800000});
        send_hit('{1'b0, 16'hffff, 24'sh000001, 24'sh7fffff, 16'hffff,
                   24'sh000001, 24'sh7fffff});
        send_hit('{1'b0, 16'h0001, 24'sh000001, 24'sh000000, 16'h0001,
                   -24'sh000001, 24'sh000000});

        // track overflow past the hit limit
        send_hit(rand_hit(1'b1));
        for (int i = 0; i < iwlf_pkg::MAX_HITS + 4; i++)
            send_hit(rand_hit(1'b0));

        for (int ph = 0; ph < 4; ph++)
        begin
            int n;
            tx_idle_pct = (ph == 1) ? 59 : (ph == 3) ? 22 : 0;
            rx_stall_pct = (ph == 2) ? 59 : (ph == 3) ? 22 : 0;
            n = 0;
            while (n < 110)
            begin
                int len;
                len = $urandom_range(12, 1);
                send_track(len);
                n += len;
            end
        end

        push = 1'b0;
        while (sb.pending_fits.size() != 0) @(posedge clk);
        repeat (500) @(posedge clk);
        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
`default_nettype wire
